/* sv/assert_macros.svh */
// Assertion macros used by the checker module of the CRC scrub checker.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies another condition in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another condition in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/csc_pkg.sv */
// Package of the CRC scrub checker: CRC constants, pass status codes and the
// evaluation struct. It depends on nothing else.
package csc_pkg;

    localparam int unsigned CrcW  = 32;
    localparam int unsigned ByteW = 8;
    localparam int unsigned DiffW = 16;

    localparam logic [CrcW-1:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CrcW-1:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CrcW-1:0] CRC_XOROUT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        STATUS_BASELINE = 2'd0,
        STATUS_MATCH    = 2'd1,
        STATUS_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        logic [CrcW-1:0]  running_next;
        logic [CrcW-1:0]  crc_final;
        status_t          status;
        logic             fault_next;
        logic [DiffW-1:0] diff_low;
        logic             baseline_take;
    } eval_t;

endpackage

/* sv/csc_pass_eval.sv */
// Folds one byte into the reflected CRC-32 and evaluates the end of a pass
// against the stored baseline. Depends on csc_pkg.
module csc_pass_eval
(
    input  logic [csc_pkg::CrcW-1:0]  running_crc,
    input  logic [csc_pkg::ByteW-1:0] data_byte,
    input  logic [csc_pkg::CrcW-1:0]  baseline_crc,
    input  logic                      baseline_held,
    input  logic                      fault_flag,
    output csc_pkg::eval_t            eval
);

    logic [csc_pkg::CrcW-1:0] crc_fold;
    logic [csc_pkg::CrcW-1:0] crc_done;
    logic [csc_pkg::CrcW-1:0] crc_diff;

    always_comb
    begin
        crc_fold = running_crc ^ {{(csc_pkg::CrcW-csc_pkg::ByteW){1'b0}}, data_byte};
        for (int k = 0; k < csc_pkg::ByteW; k++)
        begin
            if (crc_fold[0])
            begin
                crc_fold = (crc_fold >> 1) ^ csc_pkg::CRC_POLY;
            end
            else
            begin
                crc_fold = crc_fold >> 1;
            end
        end
    end

    assign crc_done = crc_fold ^ csc_pkg::CRC_XOROUT;
    assign crc_diff = crc_done ^ baseline_crc;

    always_comb
    begin
        eval.running_next  = crc_fold;
        eval.crc_final     = crc_done;
        eval.baseline_take = 1'b0;
        eval.diff_low      = '0;
        eval.fault_next    = fault_flag;
        priority if (!baseline_held)
        begin
            eval.status        = csc_pkg::STATUS_BASELINE;
            eval.baseline_take = 1'b1;
        end
        else if (crc_diff != '0)
        begin
            eval.status     = csc_pkg::STATUS_MISMATCH;
            eval.fault_next = 1'b1;
            eval.diff_low   = crc_diff[csc_pkg::DiffW-1:0];
        end
        else
        begin
            eval.status     = csc_pkg::STATUS_MATCH;
            eval.fault_next = 1'b0;
        end
    end

endmodule

/* sv/crc32_scrub_checker_core.sv */
// Top level of the CRC scrub checker. Depends on csc_pkg and csc_pass_eval.
//
// The block takes one byte of a memory region per transfer and folds it into
// a reflected CRC-32 (IEEE 802.3). It accepts one transfer every cycle; a byte
// passes an input register and then the result register, and the result of a
// pass is shown on the output from that result register. The rate drops below one
// transfer per cycle only while a finished result is held by out_stall and the
// next item would produce another one. The first completed pass sets the
// baseline; later passes report match or mismatch. An invalidate transfer
// (mode high) drops the baseline and produces no result.
module crc32_scrub_checker_core
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [csc_pkg::ByteW-1:0]  data_byte,
    input  logic                       last_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [csc_pkg::CrcW-1:0]   crc_value,
    output logic [1:0]                 pass_status,
    output logic                       fault_active,
    output logic [csc_pkg::DiffW-1:0]  diff_low
);

    logic                       s1_valid_reg;
    logic                       s1_mode_reg;
    logic [csc_pkg::ByteW-1:0]  s1_byte_reg;
    logic                       s1_last_reg;

    logic [csc_pkg::CrcW-1:0]   running_crc_reg;
    logic [csc_pkg::CrcW-1:0]   baseline_crc_reg;
    logic                       baseline_held_reg;
    logic                       fault_flag_reg;

    logic                       out_valid_reg;
    logic [csc_pkg::CrcW-1:0]   crc_value_reg;
    csc_pkg::status_t           pass_status_reg;
    logic                       fault_active_reg;
    logic [csc_pkg::DiffW-1:0]  diff_low_reg;

    csc_pkg::eval_t             eval;
    logic                       s1_result;
    logic                       out_free;
    logic                       s1_fire;
    logic                       in_take;

    csc_pass_eval u_eval
    (
        .running_crc   (running_crc_reg),
        .data_byte     (s1_byte_reg),
        .baseline_crc  (baseline_crc_reg),
        .baseline_held (baseline_held_reg),
        .fault_flag    (fault_flag_reg),
        .eval          (eval)
    );

    assign s1_result = !s1_mode_reg && s1_last_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && (!s1_result || out_free);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mode;
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg   <= csc_pkg::CRC_INIT;
            baseline_crc_reg  <= '0;
            baseline_held_reg <= 1'b0;
            fault_flag_reg    <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_mode_reg)
            begin
                baseline_crc_reg  <= '0;
                baseline_held_reg <= 1'b0;
            end
            else if (!s1_last_reg)
            begin
                running_crc_reg <= eval.running_next;
            end
            else
            begin
                running_crc_reg <= csc_pkg::CRC_INIT;
                fault_flag_reg  <= eval.fault_next;
                if (eval.baseline_take)
                begin
                    baseline_crc_reg  <= eval.crc_final;
                    baseline_held_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_result)
        begin
            crc_value_reg    <= eval.crc_final;
            pass_status_reg  <= eval.status;
            fault_active_reg <= eval.fault_next;
            diff_low_reg     <= eval.diff_low;
        end
    end

    assign out_valid    = out_valid_reg;
    assign crc_value    = crc_value_reg;
    assign pass_status  = pass_status_reg;
    assign fault_active = fault_active_reg;
    assign diff_low     = diff_low_reg;

endmodule

/* sv/csc_checker.sv */
// Port-level checker for the CRC scrub checker and its bind to the top level.
// Depends on csc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csc_checker
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [csc_pkg::CrcW-1:0]   crc_value,
    input logic [1:0]                 pass_status,
    input logic                       fault_active,
    input logic [csc_pkg::DiffW-1:0]  diff_low
);

    logic                                    is_match;
    logic                                    is_mismatch;
    logic [csc_pkg::CrcW+csc_pkg::DiffW+2:0] out_word;

    assign is_match    = out_valid && (pass_status == csc_pkg::STATUS_MATCH);
    assign is_mismatch = out_valid && (pass_status == csc_pkg::STATUS_MISMATCH);
    assign out_word    = {crc_value, pass_status, fault_active, diff_low};

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "stalled result changed")
    `ASSERT_SAME(a_match_clear, is_match, !fault_active && diff_low == '0, "match must clear fault")
    `ASSERT_SAME(a_mismatch_fault, is_mismatch, fault_active, "mismatch must raise the fault")
    `ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")

endmodule

bind crc32_scrub_checker_core csc_checker u_csc_checker (.*);

/* dv/tb_crc32_scrub_checker_core.sv */
// Testbench for crc32_scrub_checker_core: directed and random scrub passes with
// random gaps and output stalls, each result checked against a CRC-32 predictor.
// Depends on csc_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_crc32_scrub_checker_core;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned RandomItems   = 530;

    typedef struct {
        logic [csc_pkg::CrcW-1:0]  crc;
        csc_pkg::status_t          status;
        logic                      fault;
        logic [csc_pkg::DiffW-1:0] diff;
    } scrub_result_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       mode = 1'b0;
    logic [csc_pkg::ByteW-1:0]  data_byte = '0;
    logic                       last_byte = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [csc_pkg::CrcW-1:0]   crc_value;
    logic [1:0]                 pass_status;
    logic                       fault_active;
    logic [csc_pkg::DiffW-1:0]  diff_low;

    logic [csc_pkg::CrcW-1:0]   crc_acc = csc_pkg::CRC_INIT;
    logic [csc_pkg::CrcW-1:0]   golden_crc = '0;
    logic                       golden_valid = 1'b0;
    logic                       fault_seen = 1'b0;
    scrub_result_t              pending_results[$];

    int unsigned       errors = 0;
    int unsigned       items_sent = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       stall_left = 0;
    bit                idle_on = 1'b1;
    bit                stall_on = 1'b1;

    crc32_scrub_checker_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .crc_value    (crc_value),
        .pass_status  (pass_status),
        .fault_active (fault_active),
        .diff_low     (diff_low)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int unsigned pause_len();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                return 0;
            else if (r < 93)
                return $urandom_range(1, 3);
            else
                return $urandom_range(6, 24);
        end
    endfunction

    function automatic logic [csc_pkg::CrcW-1:0] fold_crc_byte(
        logic [csc_pkg::CrcW-1:0] crc, logic [csc_pkg::ByteW-1:0] b);
        logic [csc_pkg::CrcW-1:0] c;
        begin
            c = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                c = c[0] ? ((c >> 1) ^ csc_pkg::CRC_POLY) : (c >> 1);
            return c;
        end
    endfunction

    function automatic void fold_transfer(logic m, logic [csc_pkg::ByteW-1:0] b, logic l);
        scrub_result_t res;
        begin
            if (m)
            begin
                golden_valid = 1'b0;
                golden_crc = '0;
                return;
            end
            crc_acc = fold_crc_byte(crc_acc, b);
            if (!l)
                return;
            res.crc = crc_acc ^ csc_pkg::CRC_XOROUT;
            res.diff = '0;
            crc_acc = csc_pkg::CRC_INIT;
            if (!golden_valid)
            begin
                golden_crc = res.crc;
                golden_valid = 1'b1;
                res.status = csc_pkg::STATUS_BASELINE;
            end
            else if (res.crc != golden_crc)
            begin
                fault_seen = 1'b1;
                res.diff = res.crc[csc_pkg::DiffW-1:0] ^ golden_crc[csc_pkg::DiffW-1:0];
                res.status = csc_pkg::STATUS_MISMATCH;
            end
            else
            begin
                fault_seen = 1'b0;
                res.status = csc_pkg::STATUS_MATCH;
            end
            res.fault = fault_seen;
            pending_results.push_back(res);
        end
    endfunction

    task automatic send_item(input logic m, input logic [csc_pkg::ByteW-1:0] b,
                             input logic l);
        int unsigned gap;
        begin
            gap = idle_on ? pause_len() : 0;
            @(negedge clk);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            mode <= m;
            data_byte <= b;
            last_byte <= l;
            do @(posedge clk); while (in_stall);
            fold_transfer(m, b, l);
            items_sent++;
        end
    endtask

    task automatic report_mismatch(input string msg);
        begin
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        scrub_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result crc %h with none pending", crc_value));
            else
            begin
                exp_res = pending_results.pop_front();
                if (crc_value !== exp_res.crc)
                    report_mismatch($sformatf("crc_value %h, expected %h",
                                              crc_value, exp_res.crc));
                if (pass_status !== exp_res.status)
                    report_mismatch($sformatf("pass_status %0d, expected %s",
                                              pass_status, exp_res.status.name()));
                if (fault_active !== exp_res.fault)
                    report_mismatch($sformatf("fault_active %b, expected %b",
                                              fault_active, exp_res.fault));
                if (diff_low !== exp_res.diff)
                    report_mismatch($sformatf("diff_low %h, expected %h",
                                              diff_low, exp_res.diff));
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (stall_on)
                stall_left <= pause_len();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_baseline_match_mismatch();
        begin
            send_item(1'b0, 8'h00, 1'b1);
            send_item(1'b0, 8'h00, 1'b1);
            send_item(1'b0, 8'hFF, 1'b1);
        end
    endtask

    task automatic test_invalidate();
        begin
            send_item(1'b1, 8'hFF, 1'b1);
            send_item(1'b0, 8'h00, 1'b1);
            send_item(1'b0, 8'h00, 1'b1);
            send_item(1'b0, 8'hA5, 1'b0);
            send_item(1'b1, 8'h00, 1'b0);
            send_item(1'b0, 8'h5A, 1'b1);
        end
    endtask

    task automatic test_check_vector();
        logic [csc_pkg::ByteW-1:0] digits[9];
        begin
            for (int i = 0; i < 9; i++)
                digits[i] = 8'(8'h31 + i);
            for (int i = 0; i < 9; i++)
                send_item(1'b0, digits[i], i == 8);
        end
    endtask

    task automatic test_random_passes(input int unsigned n_items);
        logic [csc_pkg::ByteW-1:0] prev_region[$];
        logic [csc_pkg::ByteW-1:0] region[$];
        int unsigned      kind;
        int unsigned      len;
        int unsigned      idx;
        int               noise_at;
        int unsigned      target;
        begin
            target = items_sent + n_items;
            while (items_sent < target)
            begin
                idle_on = $urandom_range(0, 3) != 0;
                stall_on = $urandom_range(0, 3) != 0;
                kind = $urandom_range(0, 9);
                region.delete();
                if (prev_region.size() == 0 || kind < 3)
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++)
                        region.push_back(8'($urandom_range(0, 255)));
                end
                else
                begin
                    region = prev_region;
                    if (kind >= 7)
                    begin
                        idx = $urandom_range(0, region.size() - 1);
                        region[idx][$urandom_range(0, csc_pkg::ByteW - 1)] ^= 1'b1;
                    end
                end
                noise_at = ($urandom_range(0, 9) == 0) ?
                           int'($urandom_range(0, region.size())) : -1;
                for (int i = 0; i <= region.size(); i++)
                begin
                    if (i == noise_at)
                        send_item(1'b1, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                    if (i < region.size())
                        send_item(1'b0, region[i], i == region.size() - 1);
                end
                prev_region = region;
            end
        end
    endtask

    task automatic finish_run();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_baseline_match_mismatch();
        test_invalidate();
        test_check_vector();
        test_random_passes(RandomItems);
        finish_run();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
